// ===== hdl/dmsc_pkg.sv =====
package dmsc_pkg;

    localparam int MAX_WIDTH = 4096;
    localparam int X_BITS    = $clog2(MAX_WIDTH);
    localparam int W_BITS    = 13;
    localparam int H_BITS    = 16;
    localparam int PIX_BITS  = 8;
    localparam int IDX_BITS  = 2;
    localparam int CFG_BITS  = 16;

    // window indexed [column][row], column 1 / row 1 is the centre
    typedef struct packed {
        logic [2:0][2:0][PIX_BITS-1:0] win;
        logic                          le;
        logic                          ri;
        logic                          to;
        logic                          bo;
        logic                          xe;
        logic                          ye;
        logic                          pattern;
    } t_job;

endpackage

// ===== hdl/dmsc_pix_if.sv =====
interface dmsc_pix_if import dmsc_pkg::*;;
    logic                valid;
    logic                ready;
    logic                opcode;
    logic [PIX_BITS-1:0] raw_value;

    modport source (output valid, opcode, raw_value, input ready);
    modport sink (input valid, opcode, raw_value, output ready);
endinterface

// ===== hdl/dmsc_cfg_if.sv =====
interface dmsc_cfg_if import dmsc_pkg::*;;
    logic                valid;
    logic                ready;
    logic [IDX_BITS-1:0] index;
    logic [CFG_BITS-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/dmsc_rgb_if.sv =====
interface dmsc_rgb_if import dmsc_pkg::*;;
    logic                valid;
    logic                ready;
    logic [PIX_BITS-1:0] red;
    logic [PIX_BITS-1:0] green;
    logic [PIX_BITS-1:0] blue;
    logic                row_end;
    logic                frame_end;

    modport source (output valid, red, green, blue, row_end, frame_end, input ready);
    modport sink (input valid, red, green, blue, row_end, frame_end, output ready);
endinterface

// ===== hdl/dmsc_front.sv =====
module dmsc_front import dmsc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dmsc_pix_if.sink   i_pix,
    dmsc_cfg_if.sink   i_cfg,
    input  logic       i_full,
    output logic       o_push,
    output t_job       o_job
);

    localparam logic [IDX_BITS-1:0] REG_WIDTH   = 2'd0;
    localparam logic [IDX_BITS-1:0] REG_HEIGHT  = 2'd1;
    localparam logic [IDX_BITS-1:0] REG_PATTERN = 2'd2;

    logic [W_BITS-1:0] r_width;
    logic [H_BITS-1:0] r_height;
    logic              r_pattern;

    logic [X_BITS-1:0] r_in_x, n_in_x;
    logic [H_BITS:0]   r_in_y, n_in_y;
    logic [X_BITS-1:0] r_out_x, n_out_x;
    logic [H_BITS-1:0] r_out_y, n_out_y;

    logic [W_BITS-1:0] w;
    logic [H_BITS:0]   h;
    logic              cfg_wr, restart, take, fire, emit, ctr2, last;
    logic              le, ri, to, bo;
    logic [W_BITS-1:0] in_x1, out_x1;

    // stage a: line store read in flight
    logic              r_a_valid, r_a_emit, r_a_ctr2, r_a_par;
    logic [X_BITS-1:0] r_a_x;
    logic [PIX_BITS-1:0] r_a_pix;
    logic [5:0]        r_a_flags;
    logic              a_adv;

    logic [2*PIX_BITS-1:0] r_mem [MAX_WIDTH];
    logic [2*PIX_BITS-1:0] r_rd, r_byp_data, rd, wr_data;
    logic                  r_byp;
    logic [PIX_BITS-1:0]   old_px, mid_px;
    logic [2:0][2:0][PIX_BITS-1:0] r_win, win_n;

    assign i_cfg.ready = 1'b1;
    assign cfg_wr  = i_cfg.valid;
    assign restart = cfg_wr && (i_cfg.index == REG_WIDTH || i_cfg.index == REG_HEIGHT
                                || i_cfg.index == REG_PATTERN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= W_BITS'(640);
            r_height  <= H_BITS'(480);
            r_pattern <= 1'b0;
        end else if (cfg_wr) begin
            unique case (i_cfg.index)
                REG_WIDTH:   r_width   <= i_cfg.data[W_BITS-1:0];
                REG_HEIGHT:  r_height  <= i_cfg.data[H_BITS-1:0];
                REG_PATTERN: r_pattern <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_width < W_BITS'(2)) begin
            w = W_BITS'(2);
        end else if (r_width > W_BITS'(MAX_WIDTH)) begin
            w = W_BITS'(MAX_WIDTH);
        end else begin
            w = r_width;
        end
        h = (r_height < H_BITS'(2)) ? (H_BITS+1)'(2) : {1'b0, r_height};
    end

    assign a_adv       = r_a_valid && (!r_a_emit || !i_full);
    assign i_pix.ready = !r_a_valid || a_adv;

    assign take  = i_pix.opcode ? (r_in_y >= h) : (r_in_y < h);
    assign fire  = i_pix.valid && i_pix.ready && take;
    assign emit  = (r_in_y >= (H_BITS+1)'(2)) || (r_in_y == (H_BITS+1)'(1) && r_in_x != '0);
    assign ctr2  = (r_in_x == '0);
    assign le    = (r_out_x == '0);
    assign ri    = ({1'b0, r_out_x} == w - W_BITS'(1));
    assign to    = (r_out_y == '0);
    assign bo    = ({1'b0, r_out_y} == h - (H_BITS+1)'(1));
    assign last  = emit && ri && bo;
    assign in_x1  = {1'b0, r_in_x} + W_BITS'(1);
    assign out_x1 = {1'b0, r_out_x} + W_BITS'(1);

    always_comb begin
        n_in_x  = r_in_x;
        n_in_y  = r_in_y;
        n_out_x = r_out_x;
        n_out_y = r_out_y;
        if (restart) begin
            n_in_x  = '0;
            n_in_y  = '0;
            n_out_x = '0;
            n_out_y = '0;
        end else if (fire) begin
            if (last) begin
                n_in_x  = '0;
                n_in_y  = '0;
                n_out_x = '0;
                n_out_y = '0;
            end else begin
                if (in_x1 >= w) begin
                    n_in_x = '0;
                    n_in_y = r_in_y + (H_BITS+1)'(1);
                end else begin
                    n_in_x = in_x1[X_BITS-1:0];
                end
                if (emit) begin
                    if (out_x1 >= w) begin
                        n_out_x = '0;
                        n_out_y = r_out_y + H_BITS'(1);
                    end else begin
                        n_out_x = out_x1[X_BITS-1:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_x    <= '0;
            r_in_y    <= '0;
            r_out_x   <= '0;
            r_out_y   <= '0;
            r_a_valid <= 1'b0;
        end else begin
            r_in_x  <= n_in_x;
            r_in_y  <= n_in_y;
            r_out_x <= n_out_x;
            r_out_y <= n_out_y;
            if (fire) begin
                r_a_valid <= 1'b1;
            end else if (a_adv) begin
                r_a_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_a_emit   <= emit;
            r_a_ctr2   <= ctr2;
            r_a_par    <= r_in_y[0];
            r_a_x      <= r_in_x;
            r_a_pix    <= i_pix.opcode ? '0 : i_pix.raw_value;
            r_a_flags  <= {le, ri, to, bo, ~r_out_x[0], ~r_out_y[0]};
            r_byp      <= a_adv && (r_a_x == r_in_x);
            r_byp_data <= wr_data;
        end
    end

    // line store, both rows of one column in one word
    always_ff @(posedge i_clk) begin
        if (a_adv) begin
            r_mem[r_a_x] <= wr_data;
        end
        if (fire) begin
            r_rd <= r_mem[r_in_x];
        end
    end

    assign rd      = r_byp ? r_byp_data : r_rd;
    assign old_px  = r_a_par ? rd[2*PIX_BITS-1:PIX_BITS] : rd[PIX_BITS-1:0];
    assign mid_px  = r_a_par ? rd[PIX_BITS-1:0] : rd[2*PIX_BITS-1:PIX_BITS];
    assign wr_data = r_a_par ? {r_a_pix, rd[PIX_BITS-1:0]}
                             : {rd[2*PIX_BITS-1:PIX_BITS], r_a_pix};

    always_comb begin
        win_n[0] = r_win[1];
        win_n[1] = r_win[2];
        win_n[2] = {r_a_pix, mid_px, old_px};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (a_adv) begin
            r_win <= win_n;
        end
    end

    always_comb begin
        o_job.win[0] = win_n[0];
        o_job.win[1] = win_n[1];
        o_job.win[2] = r_a_ctr2 ? '0 : win_n[2];
        {o_job.le, o_job.ri, o_job.to, o_job.bo, o_job.xe, o_job.ye} = r_a_flags;
        o_job.pattern = r_pattern;
    end

    assign o_push = a_adv && r_a_emit;

endmodule

// ===== hdl/dmsc_fifo.sv =====
module dmsc_fifo import dmsc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_job o_head
);

    t_job       r_slot [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_head  = r_slot[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_job;
        end
    end

endmodule

// ===== hdl/dmsc_back.sv =====
module dmsc_back import dmsc_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_empty,
    input  t_job         i_job,
    output logic         o_pop,
    dmsc_rgb_if.source   o_rgb
);

    localparam logic [1:0] CH_R = 2'd0;
    localparam logic [1:0] CH_G = 2'd1;
    localparam logic [1:0] CH_B = 2'd2;

    typedef logic [PIX_BITS-1:0] t_pix;

    function automatic logic [1:0] site_colour(logic pat, logic xo, logic yo);
        logic [1:0] c;
        if (!pat) begin
            if (!xo && yo) c = CH_B;
            else if (xo && !yo) c = CH_R;
            else c = CH_G;
        end else begin
            if (!xo && !yo) c = CH_B;
            else if (xo && yo) c = CH_R;
            else c = CH_G;
        end
        return c;
    endfunction

    function automatic t_pix pv(t_job j, logic [1:0] ch, int dx, int dy);
        logic       xo, yo;
        logic [1:0] ci, ri;
        xo = ~j.xe ^ dx[0];
        yo = ~j.ye ^ dy[0];
        ci = 2'(1 + dx);
        ri = 2'(1 + dy);
        return (site_colour(j.pattern, xo, yo) == ch) ? j.win[ci][ri] : '0;
    endfunction

    function automatic t_pix a2(t_pix a, t_pix b);
        logic [PIX_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[PIX_BITS:1];
    endfunction

    function automatic t_pix a4(t_pix a, t_pix b, t_pix c, t_pix d);
        logic [PIX_BITS+1:0] s;
        s = {2'b0, a} + {2'b0, b} + {2'b0, c} + {2'b0, d};
        return s[PIX_BITS+1:2];
    endfunction

    t_job j;
    t_pix c_r, c_g, c_b;
    logic r_valid;

    assign j = i_job;

    always_comb begin
        c_r = '0;
        c_g = '0;
        c_b = '0;
        if (!j.pattern) begin
            if (j.le && j.to) begin
                c_r = pv(j, CH_R, 1, 0); c_g = pv(j, CH_G, 0, 0); c_b = pv(j, CH_B, 0, 1);
            end else if (j.le && j.bo) begin
                c_r = pv(j, CH_R, 1, -1);
                c_g = a2(pv(j, CH_G, 0, -1), pv(j, CH_G, 1, 0));
                c_b = pv(j, CH_B, 0, 0);
            end else if (j.ri && j.bo) begin
                c_r = pv(j, CH_R, 0, -1); c_g = pv(j, CH_G, 0, 0); c_b = pv(j, CH_B, -1, 0);
            end else if (j.ri && j.to) begin
                c_r = pv(j, CH_R, 0, 0);
                c_g = a2(pv(j, CH_G, 0, 1), pv(j, CH_G, -1, 0));
                c_b = pv(j, CH_B, -1, 1);
            end else if (j.le) begin
                c_r = !j.ye ? a2(pv(j, CH_R, 1, -1), pv(j, CH_R, 1, 1)) : pv(j, CH_R, 1, 0);
                c_g = !j.ye ? a2(pv(j, CH_G, 0, -1), pv(j, CH_G, 1, 0)) : pv(j, CH_G, 0, 0);
                c_b = j.ye ? a2(pv(j, CH_B, 0, -1), pv(j, CH_B, 0, 1)) : pv(j, CH_B, 0, 0);
            end else if (j.ri) begin
                c_r = !j.ye ? a2(pv(j, CH_R, 0, -1), pv(j, CH_R, 0, 1)) : pv(j, CH_R, 0, 0);
                c_g = j.ye ? a2(pv(j, CH_G, 0, -1), pv(j, CH_G, -1, 0)) : pv(j, CH_G, 0, 0);
                c_b = j.ye ? a2(pv(j, CH_B, -1, -1), pv(j, CH_B, -1, 1))
                           : pv(j, CH_B, -1, 0);
            end else if (j.to) begin
                c_r = j.xe ? a2(pv(j, CH_R, -1, 0), pv(j, CH_R, 1, 0)) : pv(j, CH_R, 0, 0);
                c_g = !j.xe ? a2(pv(j, CH_G, 1, 0), pv(j, CH_G, 0, 1)) : pv(j, CH_G, 0, 0);
                c_b = !j.xe ? a2(pv(j, CH_B, 1, 1), pv(j, CH_B, -1, 1)) : pv(j, CH_B, 0, 1);
            end else if (j.bo) begin
                c_r = j.xe ? a2(pv(j, CH_R, -1, -1), pv(j, CH_R, 1, -1))
                           : pv(j, CH_R, 0, -1);
                c_g = j.xe ? a2(pv(j, CH_G, 0, -1), pv(j, CH_G, 1, 0)) : pv(j, CH_G, 0, 0);
                c_b = !j.xe ? a2(pv(j, CH_B, 1, 0), pv(j, CH_B, -1, 0)) : pv(j, CH_B, 0, 0);
            end else if (j.xe && j.ye) begin
                c_r = a2(pv(j, CH_R, -1, 0), pv(j, CH_R, 1, 0));
                c_g = pv(j, CH_G, 0, 0);
                c_b = a2(pv(j, CH_B, 0, -1), pv(j, CH_B, 0, 1));
            end else if (j.xe) begin
                c_r = a4(pv(j, CH_R, -1, -1), pv(j, CH_R, 1, -1),
                         pv(j, CH_R, 1, 1), pv(j, CH_R, -1, 1));
                c_g = a4(pv(j, CH_G, -1, 0), pv(j, CH_G, 0, -1),
                         pv(j, CH_G, 0, 1), pv(j, CH_G, 1, 0));
                c_b = pv(j, CH_B, 0, 0);
            end else if (j.ye) begin
                c_r = pv(j, CH_R, 0, 0);
                c_g = a4(pv(j, CH_G, -1, 0), pv(j, CH_G, 0, -1),
                         pv(j, CH_G, 0, 1), pv(j, CH_G, 1, 0));
                c_b = a4(pv(j, CH_B, -1, -1), pv(j, CH_B, 1, -1),
                         pv(j, CH_B, 1, 1), pv(j, CH_B, -1, 1));
            end else begin
                c_r = a2(pv(j, CH_R, 0, -1), pv(j, CH_R, 0, 1));
                c_g = pv(j, CH_G, 0, 0);
                c_b = a2(pv(j, CH_B, -1, 0), pv(j, CH_B, 1, 0));
            end
        end else begin
            if (j.le && j.to) begin
                c_r = pv(j, CH_R, 1, 1);
                c_g = a2(pv(j, CH_G, 1, 0), pv(j, CH_G, 0, 1));
                c_b = pv(j, CH_B, 0, 0);
            end else if (j.le && j.bo) begin
                c_r = pv(j, CH_R, 1, 0); c_g = pv(j, CH_G, 0, 0); c_b = pv(j, CH_B, 0, -1);
            end else if (j.ri && j.bo) begin
                c_r = pv(j, CH_R, 0, 0);
                c_g = a2(pv(j, CH_G, -1, 0), pv(j, CH_G, 0, -1));
                c_b = pv(j, CH_B, -1, -1);
            end else if (j.ri && j.to) begin
                c_r = pv(j, CH_R, 0, 1); c_g = pv(j, CH_G, 0, 0); c_b = pv(j, CH_B, -1, 0);
            end else if (j.le) begin
                c_r = j.ye ? a2(pv(j, CH_R, 1, -1), pv(j, CH_R, 1, 1)) : pv(j, CH_R, 1, 0);
                c_g = j.ye ? a2(pv(j, CH_G, 0, -1), pv(j, CH_G, 1, 0)) : pv(j, CH_G, 0, 0);
                c_b = !j.ye ? a2(pv(j, CH_B, 0, -1), pv(j, CH_B, 0, 1)) : pv(j, CH_B, 0, 0);
            end else if (j.ri) begin
                c_r = j.ye ? a2(pv(j, CH_R, 0, -1), pv(j, CH_R, 0, 1)) : pv(j, CH_R, 0, 0);
                c_g = !j.ye ? a2(pv(j, CH_G, 0, -1), pv(j, CH_G, -1, 0)) : pv(j, CH_G, 0, 0);
                c_b = !j.ye ? a2(pv(j, CH_B, -1, -1), pv(j, CH_B, -1, 1))
                            : pv(j, CH_B, -1, 0);
            end else if (j.to) begin
                c_r = j.xe ? a2(pv(j, CH_R, 1, 1), pv(j, CH_R, -1, 1)) : pv(j, CH_R, 0, 1);
                c_g = j.xe ? a2(pv(j, CH_G, 1, 0), pv(j, CH_G, 0, 1)) : pv(j, CH_G, 0, 0);
                c_b = !j.xe ? a2(pv(j, CH_B, -1, 0), pv(j, CH_B, 1, 0)) : pv(j, CH_B, 0, 0);
            end else if (j.bo) begin
                c_r = j.xe ? a2(pv(j, CH_R, -1, 0), pv(j, CH_R, 1, 0)) : pv(j, CH_R, 0, 0);
                c_g = !j.xe ? a2(pv(j, CH_G, -1, 0), pv(j, CH_G, 0, -1)) : pv(j, CH_G, 0, 0);
                c_b = !j.xe ? a2(pv(j, CH_B, 1, -1), pv(j, CH_B, -1, -1))
                            : pv(j, CH_B, 0, -1);
            end else if (j.xe && j.ye) begin
                c_r = a4(pv(j, CH_R, -1, -1), pv(j, CH_R, 1, -1),
                         pv(j, CH_R, 1, 1), pv(j, CH_R, -1, 1));
                c_g = a4(pv(j, CH_G, -1, 0), pv(j, CH_G, 0, -1),
                         pv(j, CH_G, 0, 1), pv(j, CH_G, 1, 0));
                c_b = pv(j, CH_B, 0, 0);
            end else if (j.xe) begin
                c_r = a2(pv(j, CH_R, -1, 0), pv(j, CH_R, 1, 0));
                c_g = pv(j, CH_G, 0, 0);
                c_b = a2(pv(j, CH_B, 0, -1), pv(j, CH_B, 0, 1));
            end else if (j.ye) begin
                c_r = a2(pv(j, CH_R, 0, -1), pv(j, CH_R, 0, 1));
                c_g = pv(j, CH_G, 0, 0);
                c_b = a2(pv(j, CH_B, -1, 0), pv(j, CH_B, 1, 0));
            end else begin
                c_r = pv(j, CH_R, 0, 0);
                c_g = a4(pv(j, CH_G, -1, 0), pv(j, CH_G, 0, -1),
                         pv(j, CH_G, 0, 1), pv(j, CH_G, 1, 0));
                c_b = a4(pv(j, CH_B, -1, -1), pv(j, CH_B, 1, -1),
                         pv(j, CH_B, 1, 1), pv(j, CH_B, -1, 1));
            end
        end
    end

    assign o_pop       = !i_empty && (!r_valid || o_rgb.ready);
    assign o_rgb.valid = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (o_rgb.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            o_rgb.red       <= c_r;
            o_rgb.green     <= c_g;
            o_rgb.blue      <= c_b;
            o_rgb.row_end   <= j.ri;
            o_rgb.frame_end <= j.ri && j.bo;
        end
    end

endmodule

// ===== hdl/bayer_bilinear_demosaic_unit.sv =====
// Bilinear Bayer demosaic: raw pixels (opcode 0) stream in raster order and one RGB
// transaction leaves per position, one row plus one pixel behind the input, so the first
// frame_width+1 pixels of a frame give no result; after the frame's last pixel,
// frame_width+1 flush transactions (opcode 1) drain the rest, the last one marked
// frame_end. One transaction is taken per clock while nothing stalls: each item does one
// read and one write of the line store (MAX_WIDTH words, both rows of a column per word),
// and the front, a two-entry queue and the registered back stage each stall on their own.
// A result passes from stage a through the queue into the registered back stage. Register
// writes restart the frame and belong between frames; the line store needs no clearing
// after reset.
module bayer_bilinear_demosaic_unit import dmsc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dmsc_pix_if.sink    i_pix,
    dmsc_cfg_if.sink    i_cfg,
    dmsc_rgb_if.source  o_rgb
);

    logic s_push, s_pop, s_full, s_empty;
    t_job s_job, s_head;

    dmsc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (i_pix),
        .i_cfg   (i_cfg),
        .i_full  (s_full),
        .o_push  (s_push),
        .o_job   (s_job)
    );

    dmsc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_push),
        .i_job   (s_job),
        .i_pop   (s_pop),
        .o_full  (s_full),
        .o_empty (s_empty),
        .o_head  (s_head)
    );

    dmsc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (s_empty),
        .i_job   (s_head),
        .o_pop   (s_pop),
        .o_rgb   (o_rgb)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_push |-> !s_full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_pop |-> !s_empty)
        else $error("queue read while empty");

    a_frame_end_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rgb.valid && o_rgb.frame_end) |-> o_rgb.row_end)
        else $error("frame end without row end");

endmodule
